/* src/mcfts_pkg.sv */
package mcfts_pkg;

  localparam int FRAME_BYTES = 128;

  // Command codes on the input word.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_XFER  = 2'd2;

  // Read result codes.
  localparam logic [1:0] RES_OK   = 2'd0;
  localparam logic [1:0] RES_CSUM = 2'd1;
  localparam logic [1:0] RES_END  = 2'd2;

  // Protocol bytes.
  localparam logic [7:0] BYTE_ACCESS = 8'h81;
  localparam logic [7:0] BYTE_READ   = 8'h52;
  localparam logic [7:0] BYTE_WRITE  = 8'h57;
  localparam logic [7:0] BYTE_END_OK = 8'h47;

  // Slot numbers; slot 0 carries the access byte.
  localparam logic [7:0] SLOT_CMD      = 8'd1;
  localparam logic [7:0] SLOT_HDR0     = 8'd2;
  localparam logic [7:0] SLOT_HDR1     = 8'd3;
  localparam logic [7:0] SLOT_ADDR_HI  = 8'd4;
  localparam logic [7:0] SLOT_ADDR_LO  = 8'd5;
  localparam logic [7:0] SLOT_ECHO_HI  = 8'd8;
  localparam logic [7:0] SLOT_ECHO_LO  = 8'd9;
  localparam logic [7:0] RD_DATA0      = 8'd10;
  localparam logic [7:0] RD_CHECK      = RD_DATA0 + 8'(FRAME_BYTES);
  localparam logic [7:0] RD_LAST       = RD_CHECK + 8'd1;
  localparam logic [7:0] WR_DATA0      = 8'd6;
  localparam logic [7:0] WR_CHECK      = WR_DATA0 + 8'(FRAME_BYTES);
  localparam logic [7:0] WR_STAT1      = WR_CHECK + 8'd1;
  localparam logic [7:0] WR_LAST       = WR_STAT1 + 8'd1;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [9:0] frame_address;
    logic [7:0] write_byte;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_wait_ack;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [6:0]  data_index;
    logic        done_res;
    logic [1:0]  result_code;
    logic        echo_mismatch;
    logic [15:0] write_status;
  } result_t;

endpackage

/* src/mcfts_in_stage.sv */
module mcfts_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mcfts_pkg::item_t in_item,
  input  logic             advance,
  output logic             full,
  output mcfts_pkg::item_t item
);
  import mcfts_pkg::*;

  logic take;

  assign in_stall = full && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= take || (full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= in_item;
    end
  end

endmodule

/* src/mcfts_slot_engine.sv */
module mcfts_slot_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  mcfts_pkg::item_t   item,
  output mcfts_pkg::result_t res
);
  import mcfts_pkg::*;

  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] slot_count;
  logic [7:0] slot_count_next;
  logic [9:0] latched_address;
  logic [9:0] latched_address_next;
  logic [7:0] running_xor;
  logic [7:0] running_xor_next;
  logic [7:0] received_check;
  logic [7:0] received_check_next;
  logic       echo_bad;
  logic       echo_bad_next;
  logic [7:0] first_status;
  logic [7:0] first_status_next;

  logic       start;
  logic       step;
  logic       fin;
  logic [7:0] last_slot;
  logic [7:0] ns;
  logic [7:0] addr_hi;
  logic [7:0] addr_lo;
  logic [7:0] rd_offset;

  assign start     = (item.cmd == CMD_READ) || (item.cmd == CMD_WRITE);
  assign step      = (item.cmd == CMD_XFER) && (mode != MODE_IDLE);
  assign last_slot = (mode == MODE_READ) ? RD_LAST : WR_LAST;
  assign fin       = slot_count >= last_slot;
  assign ns        = slot_count + 8'd1;
  assign addr_hi   = {6'd0, latched_address[9:8]};
  assign addr_lo   = latched_address[7:0];
  assign rd_offset = slot_count - RD_DATA0;

  always_comb begin
    mode_next = mode;
    if (start) begin
      mode_next = (item.cmd == CMD_READ) ? MODE_READ : MODE_WRITE;
    end else if (step && fin) begin
      mode_next = MODE_IDLE;
    end
  end

  always_comb begin
    res                  = '0;
    slot_count_next      = slot_count;
    latched_address_next = latched_address;
    running_xor_next     = running_xor;
    received_check_next  = received_check;
    echo_bad_next        = echo_bad;
    first_status_next    = first_status;

    if (start) begin
      latched_address_next = item.frame_address;
      slot_count_next      = '0;
      running_xor_next     = {6'd0, item.frame_address[9:8]} ^ item.frame_address[7:0];
      received_check_next  = '0;
      echo_bad_next        = 1'b0;
      first_status_next    = '0;
      res.tx_valid         = 1'b1;
      res.tx_byte          = BYTE_ACCESS;
      res.tx_wait_ack      = 1'b1;
    end else if (step) begin
      if (mode == MODE_READ) begin
        if ((slot_count == SLOT_ECHO_HI && item.rx_byte != addr_hi) ||
            (slot_count == SLOT_ECHO_LO && item.rx_byte != addr_lo)) begin
          echo_bad_next = 1'b1;
        end
        if (slot_count >= RD_DATA0 && slot_count < RD_CHECK) begin
          running_xor_next = running_xor ^ item.rx_byte;
          res.data_valid   = 1'b1;
          res.data_byte    = item.rx_byte;
          res.data_index   = rd_offset[6:0];
        end
        if (slot_count == RD_CHECK) begin
          received_check_next = item.rx_byte;
        end
        if (fin) begin
          if (received_check != running_xor) begin
            res.result_code = RES_CSUM;
          end else if (item.rx_byte != BYTE_END_OK) begin
            res.result_code = RES_END;
          end else begin
            res.result_code = RES_OK;
          end
        end
        res.echo_mismatch = echo_bad_next;
      end else begin
        if (slot_count == WR_STAT1) begin
          first_status_next = item.rx_byte;
        end
        if (fin) begin
          res.write_status = {first_status, item.rx_byte};
        end
      end

      if (fin) begin
        res.done_res    = 1'b1;
        slot_count_next = '0;
      end else begin
        slot_count_next = ns;
        res.tx_valid    = 1'b1;
        res.tx_wait_ack = (ns != last_slot);
        case (ns)
          SLOT_CMD:     res.tx_byte = (mode == MODE_READ) ? BYTE_READ : BYTE_WRITE;
          SLOT_HDR0:    res.tx_byte = 8'h00;
          SLOT_HDR1:    res.tx_byte = 8'h00;
          SLOT_ADDR_HI: res.tx_byte = addr_hi;
          SLOT_ADDR_LO: res.tx_byte = addr_lo;
          default: begin
            // Write data is folded into the checksum as it goes out.
            if (mode == MODE_WRITE && ns >= WR_DATA0 && ns < WR_CHECK) begin
              res.tx_byte      = item.write_byte;
              running_xor_next = running_xor ^ item.write_byte;
            end else if (mode == MODE_WRITE && ns == WR_CHECK) begin
              res.tx_byte = running_xor;
            end else begin
              res.tx_byte = 8'h00;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      slot_count      <= '0;
      latched_address <= '0;
      running_xor     <= '0;
      received_check  <= '0;
      echo_bad        <= 1'b0;
      first_status    <= '0;
    end else if (fire) begin
      mode            <= mode_next;
      slot_count      <= slot_count_next;
      latched_address <= latched_address_next;
      running_xor     <= running_xor_next;
      received_check  <= received_check_next;
      echo_bad        <= echo_bad_next;
      first_status    <= first_status_next;
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res.done_res |=> mode == MODE_IDLE && slot_count == 8'd0)
    else $error("transfer did not return to idle after its final slot");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_READ && slot_count <= RD_LAST) ||
    (mode == MODE_WRITE && slot_count <= WR_LAST) ||
    (mode == MODE_IDLE && slot_count == 8'd0))
    else $error("slot counter outside the transfer");

  a_slot_advances: assert property (@(posedge clk) disable iff (rst)
    fire && step && !start && !fin |=> slot_count == $past(slot_count) + 8'd1)
    else $error("slot counter did not advance on a completed word");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    fire && start |=> slot_count == 8'd0 && !echo_bad && mode != MODE_IDLE)
    else $error("start command did not open a fresh transfer");

endmodule

/* src/mcfts_out_stage.sv */
module mcfts_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  mcfts_pkg::result_t res_in,
  input  logic               out_stall,
  output logic               out_valid,
  output mcfts_pkg::result_t res
);
  import mcfts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

/* src/memory_card_frame_transfer_sequencer_core.sv */
// Host-side sequencer for one memory card frame read or write.
// Input words: cmd selects start read, start write or a completed byte
// exchange; frame_address is latched on a start, write_byte is the data
// to send when the next slot carries write data, rx_byte is what the card
// returned in the slot just completed.
// Each input word yields exactly one output word: the next byte to send
// (tx_valid, tx_byte, tx_wait_ack), any read data byte with its index, and
// on the final slot done_res with result_code, echo_mismatch or
// write_status.
// A word accepted into the input register is stepped through the slot
// logic and loaded into the output register once the output is not
// stalled, and its result is shown from there on. One word is accepted
// every cycle while the receiver does not stall; the slot state lives in
// a single register bank that updates as each word moves to the output
// register.
// When the receiver stalls, the output word holds; one more word may be
// taken into the input register, after which in_stall rises.
// Synchronous reset empties both registers and returns the sequencer to
// idle with all slot state cleared.
module memory_card_frame_transfer_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [9:0]  frame_address,
  input  logic [7:0]  write_byte,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        tx_wait_ack,
  output logic        data_valid,
  output logic [7:0]  data_byte,
  output logic [6:0]  data_index,
  output logic        done_res,
  output logic [1:0]  result_code,
  output logic        echo_mismatch,
  output logic [15:0] write_status
);
  import mcfts_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    in_full;
  logic    advance;
  result_t step_res;
  result_t res;

  assign in_item.cmd           = cmd;
  assign in_item.frame_address = frame_address;
  assign in_item.write_byte    = write_byte;
  assign in_item.rx_byte       = rx_byte;

  assign advance = in_full && !(out_valid && out_stall);

  mcfts_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .full     (in_full),
    .item     (item)
  );

  mcfts_slot_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (item),
    .res  (step_res)
  );

  mcfts_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res)
  );

  assign tx_valid      = res.tx_valid;
  assign tx_byte       = res.tx_byte;
  assign tx_wait_ack   = res.tx_wait_ack;
  assign data_valid    = res.data_valid;
  assign data_byte     = res.data_byte;
  assign data_index    = res.data_index;
  assign done_res      = res.done_res;
  assign result_code   = res.result_code;
  assign echo_mismatch = res.echo_mismatch;
  assign write_status  = res.write_status;

endmodule
